// ----- rtl/sms_pkg.sv -----
// ----------------------------------------------------------------------------
// sms_pkg
// Shared constants, derived widths and controller/datapath bundles for the
// sample mean and standard deviation core.
// ----------------------------------------------------------------------------
package sms_pkg;

	// sample port and run limits
	localparam int SAMPLE_W    = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int MAX_SAMPLES = 1024;
	localparam int FRAC_W      = 8;

	// result field widths
	localparam int TOTAL_W = 11;
	localparam int MEAN_W  = 24;
	localparam int STD_W   = 24;

	// accumulator widths
	localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
	localparam int LOG_MAX = $clog2(MAX_SAMPLES);
	localparam int SUM_W   = SAMPLE_BITS + LOG_MAX;
	localparam int SQ_W    = 2 * SAMPLE_BITS + LOG_MAX;
	localparam int XSQ_W   = 2 * SAMPLE_BITS;

	// products: n*sumsq and sum*sum, difference D = n*sumsq - sum^2
	localparam int P1_W = CNT_W + SQ_W;
	localparam int P2_W = 2 * SUM_W;
	localparam int D_W  = P1_W;

	// shared divider: dividend D << 16, divisor n*(n-1)
	localparam int DVD_W = D_W + 2 * FRAC_W;
	localparam int DVS_W = 2 * CNT_W;

	// root of the scaled variance, and the quotient feeding it
	localparam int ROOT_W = SAMPLE_BITS + FRAC_W;
	localparam int QUO_W  = 2 * ROOT_W;

	// iteration counters
	localparam int MUL_CNT_W = $clog2(SUM_W);
	localparam int DIV_CNT_W = $clog2(DVD_W);
	localparam int SQR_CNT_W = $clog2(ROOT_W);

	// controller -> datapath commands
	typedef struct packed {
		logic acc;         // accept one sample word
		logic clear;       // clear the run accumulators
		logic mean_start;  // start mean divide and both products
		logic mean_ld;     // capture the mean quotient
		logic var_start;   // start variance divide
		logic sqrt_start;  // start root of variance quotient
		logic out_ld;      // load the result register
	} sms_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic div_busy;
		logic mul_busy;
		logic sqrt_busy;
		logic single;      // run holds one sample
	} sms_sts_t;

endpackage

// ----- rtl/sms_div.sv -----
// ----------------------------------------------------------------------------
// sms_div
// Restoring divider, one quotient bit per cycle, MSB first. Shared by the
// mean and variance divides.
// ----------------------------------------------------------------------------
module sms_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sms_pkg::DVD_W-1:0]  dividend,
	input  logic [sms_pkg::DVS_W-1:0]  divisor,
	output logic                       busy,
	output logic [sms_pkg::QUO_W-1:0]  quotient
);
	import sms_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DVS_W-1:0]     rem_q;
	logic [QUO_W-1:0]     quot_q;

	logic [DVS_W:0]       cand;
	logic [DVS_W:0]       diff;
	logic                 fits;
	logic [DVS_W-1:0]     rem_nx;

	// trial subtract of the divisor from the shifted remainder
	assign cand   = {rem_q, dvd_q[DVD_W-1]};
	assign diff   = cand - {1'b0, dvs_q};
	assign fits   = cand >= {1'b0, dvs_q};
	assign rem_nx = fits ? diff[DVS_W-1:0] : cand[DVS_W-1:0];

	// control: busy from start until the last quotient bit is shifted in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DVD_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// operands and partial results; upper quotient bits are known zero
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			dvs_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q  <= rem_nx;
			quot_q <= {quot_q[QUO_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quot_q;

endmodule

// ----- rtl/sms_sqrt.sv -----
// ----------------------------------------------------------------------------
// sms_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module sms_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sms_pkg::QUO_W-1:0]   radicand,
	output logic                        busy,
	output logic [sms_pkg::ROOT_W-1:0]  root
);
	import sms_pkg::*;

	localparam int REM_W = ROOT_W + 2;

	logic                 busy_q;
	logic [SQR_CNT_W-1:0] cnt_q;
	logic [QUO_W-1:0]     rad_q;
	logic [REM_W-1:0]     rem_q;
	logic [ROOT_W-1:0]    root_q;

	logic [REM_W+1:0]     cand;
	logic [REM_W+1:0]     trial;
	logic [REM_W+1:0]     diff;
	logic                 fits;

	// bring down two radicand bits, try (root << 2) | 1
	assign cand  = {rem_q, rad_q[QUO_W-1 -: 2]};
	assign trial = (REM_W + 2)'({root_q, 2'b01});
	assign diff  = cand - trial;
	assign fits  = cand >= trial;

	// control: busy from start until the last root bit is shifted in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= SQR_CNT_W'(ROOT_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - SQR_CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// radicand shift, remainder and root
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[QUO_W-3:0], 2'b00};
			rem_q  <= fits ? diff[REM_W-1:0] : cand[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

// ----- rtl/sms_dp.sv -----
// ----------------------------------------------------------------------------
// sms_dp
// Datapath: run accumulators, serial shift-add products, shared divider,
// square root unit and the result register.
// ----------------------------------------------------------------------------
module sms_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sms_pkg::sms_cmd_t             cmd,
	input  logic [sms_pkg::SAMPLE_W-1:0]  sample,
	output sms_pkg::sms_sts_t             sts,
	output logic [sms_pkg::TOTAL_W-1:0]   sample_total,
	output logic [sms_pkg::MEAN_W-1:0]    mean_value,
	output logic [sms_pkg::STD_W-1:0]     std_value
);
	import sms_pkg::*;

	// run accumulators
	logic [CNT_W-1:0]       count_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SQ_W-1:0]        sq_q;
	logic [SAMPLE_BITS-1:0] x;
	logic [XSQ_W-1:0]       xsq;
	logic                   room;

	// serial products
	logic                   mul_busy_q;
	logic [MUL_CNT_W-1:0]   mul_cnt_q;
	logic [P1_W-1:0]        mca_q;
	logic [P2_W-1:0]        mcb_q;
	logic [SUM_W-1:0]       mpa_q;
	logic [SUM_W-1:0]       mpb_q;
	logic [P1_W-1:0]        p1_q;
	logic [P2_W-1:0]        p2_q;

	// divide / root operands and results
	logic [CNT_W-1:0]       cnt_m1;
	logic [DVS_W-1:0]       nn1;
	logic [DVS_W-1:0]       nn1_q;
	logic [D_W-1:0]         d_val;
	logic                   div_start;
	logic                   div_busy;
	logic [DVD_W-1:0]       div_dvd;
	logic [DVS_W-1:0]       div_dvs;
	logic [QUO_W-1:0]       quot;
	logic                   sqrt_busy;
	logic [ROOT_W-1:0]      root;
	logic [MEAN_W-1:0]      mean_q;
	logic                   single;

	// result register
	logic [TOTAL_W-1:0]     total_q;
	logic [MEAN_W-1:0]      mean_out_q;
	logic [STD_W-1:0]       std_out_q;

	assign x    = sample[SAMPLE_BITS-1:0];
	assign xsq  = x * x;
	assign room = count_q < CNT_W'(MAX_SAMPLES);

	// accumulate while the run has room, clear when the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sq_q    <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
			sum_q   <= '0;
			sq_q    <= '0;
		end else if (cmd.acc && room) begin
			count_q <= count_q + CNT_W'(1);
			sum_q   <= sum_q + SUM_W'(x);
			sq_q    <= sq_q + SQ_W'(xsq);
		end
	end

	// shift-add products n*sumsq and sum*sum, one multiplier bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_cnt_q  <= '0;
		end else if (cmd.mean_start) begin
			mul_busy_q <= 1'b1;
			mul_cnt_q  <= MUL_CNT_W'(SUM_W - 1);
		end else if (mul_busy_q) begin
			mul_cnt_q <= mul_cnt_q - MUL_CNT_W'(1);
			if (mul_cnt_q == '0) begin
				mul_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mean_start) begin
			mca_q <= P1_W'(sq_q);
			mpa_q <= SUM_W'(count_q);
			mcb_q <= P2_W'(sum_q);
			mpb_q <= sum_q;
			p1_q  <= '0;
			p2_q  <= '0;
		end else if (mul_busy_q) begin
			if (mpa_q[0]) begin
				p1_q <= p1_q + mca_q;
			end
			if (mpb_q[0]) begin
				p2_q <= p2_q + mcb_q;
			end
			mca_q <= {mca_q[P1_W-2:0], 1'b0};
			mcb_q <= {mcb_q[P2_W-2:0], 1'b0};
			mpa_q <= {1'b0, mpa_q[SUM_W-1:1]};
			mpb_q <= {1'b0, mpb_q[SUM_W-1:1]};
		end
	end

	// divisor n*(n-1), captured at the start of the run's math
	assign cnt_m1 = count_q - CNT_W'(1);
	assign nn1    = DVS_W'(count_q) * DVS_W'(cnt_m1);

	always_ff @(posedge clk) begin
		if (cmd.mean_start) begin
			nn1_q <= nn1;
		end
	end

	// D is never negative
	assign d_val = p1_q - P1_W'(p2_q);

	// divider operand select: mean (sum << 8) / n, else (D << 16) / n(n-1)
	assign div_start = cmd.mean_start | cmd.var_start;
	assign div_dvd   = cmd.mean_start ? DVD_W'({sum_q, FRAC_W'(0)})
	                                  : {d_val, (2 * FRAC_W)'(0)};
	assign div_dvs   = cmd.mean_start ? DVS_W'(count_q) : nn1_q;

	sms_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (quot)
	);

	sms_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (quot),
		.busy     (sqrt_busy),
		.root     (root)
	);

	// mean stays below 2^(SAMPLE_BITS+8), so the low bits are the value
	always_ff @(posedge clk) begin
		if (cmd.mean_ld) begin
			mean_q <= MEAN_W'(quot);
		end
	end

	assign single = count_q == CNT_W'(1);

	// result register, deviation forced to zero for a one-sample run
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			total_q    <= TOTAL_W'(count_q);
			mean_out_q <= mean_q;
			std_out_q  <= single ? '0 : STD_W'(root);
		end
	end

	assign sts.div_busy  = div_busy;
	assign sts.mul_busy  = mul_busy_q;
	assign sts.sqrt_busy = sqrt_busy;
	assign sts.single    = single;

	assign sample_total = total_q;
	assign mean_value   = mean_out_q;
	assign std_value    = std_out_q;

endmodule

// ----- rtl/sms_ctrl.sv -----
// ----------------------------------------------------------------------------
// sms_ctrl
// Controller: takes sample words, then sequences the mean divide, products,
// variance divide and root (not for one sample) and loads the result register.
// ----------------------------------------------------------------------------
module sms_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               last,
	input  logic               out_stall,
	input  sms_pkg::sms_sts_t  sts,
	output logic               in_stall,
	output logic               out_valid,
	output sms_pkg::sms_cmd_t  cmd
);
	import sms_pkg::*;

	localparam logic [2:0] ST_ACC       = 3'd0;
	localparam logic [2:0] ST_MEAN      = 3'd1;
	localparam logic [2:0] ST_MEAN_WAIT = 3'd2;
	localparam logic [2:0] ST_MUL_WAIT  = 3'd3;
	localparam logic [2:0] ST_VAR_WAIT  = 3'd4;
	localparam logic [2:0] ST_SQRT_WAIT = 3'd5;
	localparam logic [2:0] ST_FIN       = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;

	// next state and commands
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_ACC: begin
				cmd.acc = in_valid;
				if (in_valid && last) begin
					state_nx = ST_MEAN;
				end
			end
			ST_MEAN: begin
				cmd.mean_start = 1'b1;
				state_nx       = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT: begin
				if (!sts.div_busy) begin
					cmd.mean_ld = 1'b1;
					state_nx    = ST_MUL_WAIT;
				end
			end
			ST_MUL_WAIT: begin
				if (!sts.mul_busy) begin
					if (sts.single) begin
						state_nx = ST_FIN;
					end else begin
						cmd.var_start = 1'b1;
						state_nx      = ST_VAR_WAIT;
					end
				end
			end
			ST_VAR_WAIT: begin
				if (!sts.div_busy) begin
					cmd.sqrt_start = 1'b1;
					state_nx       = ST_SQRT_WAIT;
				end
			end
			ST_SQRT_WAIT: begin
				if (!sts.sqrt_busy) begin
					state_nx = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_ld = 1'b1;
					cmd.clear  = 1'b1;
					state_nx   = ST_ACC;
				end
			end
			default: begin
				state_nx = ST_ACC;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != ST_ACC;
	assign out_valid = out_valid_q;

endmodule

// ----- rtl/sample_mean_std_core.sv -----
// ----------------------------------------------------------------------------
// sample_mean_std_core: count, mean and sample std deviation of a run.
// Sample words are taken one per cycle while in_stall is low; the word marked
// last closes the run. The result follows a 69-step divider pass and, for two
// or more samples, a second pass and a 24-step root. Reset clears the run.
// ----------------------------------------------------------------------------
module sample_mean_std_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sms_pkg::SAMPLE_W-1:0]  sample,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sms_pkg::TOTAL_W-1:0]   sample_total,
	output logic [sms_pkg::MEAN_W-1:0]    mean_value,
	output logic [sms_pkg::STD_W-1:0]     std_value
);
	import sms_pkg::*;

	sms_cmd_t cmd;
	sms_sts_t sts;

	sms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.out_stall (out_stall),
		.sts       (sts),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	sms_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample       (sample),
		.sts          (sts),
		.sample_total (sample_total),
		.mean_value   (mean_value),
		.std_value    (std_value)
	);

`ifndef NO_ASSERTIONS
	// words are only taken while no arithmetic unit is running
	a_idle_when_open: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !(sts.div_busy || sts.mul_busy || sts.sqrt_busy))
		else $error("input open while a unit is busy");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!out_valid || !out_stall))
		else $error("result register overwritten");

	// variance divide starts only once the products are done
	a_var_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.var_start |-> (!sts.mul_busy && !sts.div_busy))
		else $error("variance divide started early");

	// one-sample runs skip the root
	a_single_no_root: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sqrt_start |-> !sts.single)
		else $error("root started for a one-sample run");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: sample_mean_std_core testbench
// Drives runs of sample words, each closed by a word marked last, and checks
// count, mean and sample deviation against an exact integer model. It covers
// single-word runs, extreme values, a run past the sample limit, and
// random runs under varied sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb;
	import sms_pkg::*;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [MEAN_W-1:0]  mean;
		logic [STD_W-1:0]   dev;
	} run_stats_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [SAMPLE_W-1:0] sample = '0;
	logic                last = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [TOTAL_W-1:0]  sample_total;
	logic [MEAN_W-1:0]   mean_value;
	logic [STD_W-1:0]    std_value;

	// model state for the run in progress
	logic [CNT_W-1:0]    run_words = '0;
	logic [SUM_W-1:0]    run_sum = '0;
	logic [SQ_W-1:0]     run_sq_sum = '0;
	run_stats_t          pending_stats[$];

	int                  mismatch_count = 0;
	int                  send_idle_pct = 0;
	int                  stall_pct = 0;

	sample_mean_std_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_total (sample_total),
		.mean_value   (mean_value),
		.std_value    (std_value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#4_000_000;
		$display("tb failed");
		$finish;
	end

	// floor of the square root, one result bit per pass
	function automatic logic [63:0] floor_root(input logic [63:0] v);
		logic [63:0] rest;
		logic [63:0] root;
		logic [63:0] probe;
		rest = v;
		root = '0;
		probe = 64'h1 << 62;
		while (probe > rest)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rest >= root + probe) begin
				rest = rest - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	// fold one accepted word into the run; queue the run stats on the last mark
	task automatic fold_sample(input logic [SAMPLE_W-1:0] x, input logic mark);
		logic [SAMPLE_W-1:0] v;
		logic [127:0]        spread;
		logic [127:0]        var_q;
		logic [63:0]         mean_q;
		logic [63:0]         dev;
		run_stats_t          st;
		v = x & SAMPLE_W'((64'd1 << SAMPLE_BITS) - 1);
		if (run_words < MAX_SAMPLES) begin
			run_words = run_words + CNT_W'(1);
			run_sum = run_sum + SUM_W'(v);
			run_sq_sum = run_sq_sum + SQ_W'(v) * SQ_W'(v);
		end
		if (mark) begin
			mean_q = (64'(run_sum) << 8) / 64'(run_words);
			dev = '0;
			if (run_words > 1) begin
				spread = 128'(run_words) * 128'(run_sq_sum) - 128'(run_sum) * 128'(run_sum);
				var_q = (spread << 16) / (128'(run_words) * 128'(run_words - CNT_W'(1)));
				if (var_q[127:64] != 0)
					dev = 64'hFF_FFFF;
				else
					dev = floor_root(var_q[63:0]);
				if (dev > 64'hFF_FFFF)
					dev = 64'hFF_FFFF;
			end
			st.total = TOTAL_W'(run_words);
			st.mean = (mean_q > 64'hFF_FFFF) ? 24'hFF_FFFF : MEAN_W'(mean_q);
			st.dev = STD_W'(dev);
			pending_stats.push_back(st);
			run_words = '0;
			run_sum = '0;
			run_sq_sum = '0;
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		run_stats_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_stats.size() == 0) begin
				report_mismatch("unexpected result, total", sample_total, 0);
			end else begin
				want = pending_stats.pop_front();
				if (sample_total !== want.total)
					report_mismatch("sample_total", sample_total, want.total);
				if (mean_value !== want.mean)
					report_mismatch("mean_value", mean_value, want.mean);
				if (std_value !== want.dev)
					report_mismatch("std_value", std_value, want.dev);
			end
		end
	end

	// receiver stall
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// send one word, idling first at the sender rate
	task automatic send_word(input logic [SAMPLE_W-1:0] x, input logic mark);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= x;
		last <= mark;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		fold_sample(x, mark);
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// one run of random words; shape picks the value spread
	task automatic send_run(input int len, input int shape);
		logic [SAMPLE_W-1:0] base;
		logic [SAMPLE_W-1:0] x;
		base = SAMPLE_W'($urandom);
		for (int i = 0; i < len; i++) begin
			unique case (shape)
				0: x = SAMPLE_W'($urandom);
				1: x = base ^ SAMPLE_W'($urandom_range(15));
				2: x = $urandom_range(1) ? '1 : '0;
				default: x = base;
			endcase
			send_word(x, i == len - 1);
		end
	endtask

	task automatic test_single_word();
		send_word(16'h0000, 1'b1);
		send_word(16'hFFFF, 1'b1);
		send_word(16'h5A5A, 1'b1);
		drop_valid();
	endtask

	task automatic test_spread();
		// widest spread, then a flat run at full scale, a short ramp and a mixed run
		send_word(16'h0000, 1'b0);
		send_word(16'hFFFF, 1'b1);
		repeat (2) send_word(16'hFFFF, 1'b0);
		send_word(16'hFFFF, 1'b1);
		for (int i = 1; i <= 4; i++)
			send_word(SAMPLE_W'(i), i == 4);
		send_word(16'hAAAA, 1'b0);
		send_word(16'h5555, 1'b0);
		send_word(16'hFFFF, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'h8001, 1'b1);
		drop_valid();
	endtask

	task automatic test_run_limit();
		// full scale up to the limit after one zero word: largest sums and spread;
		// the tail past the limit and its marked word are not counted
		for (int i = 0; i < MAX_SAMPLES + 6; i++) begin
			if (i == 0)
				send_word(16'h0000, 1'b0);
			else if (i < MAX_SAMPLES)
				send_word(16'hFFFF, 1'b0);
			else
				send_word(SAMPLE_W'($urandom), i == MAX_SAMPLES + 5);
		end
		drop_valid();
	endtask

	task automatic test_random_runs(input int words);
		int sent;
		int len;
		sent = 0;
		while (sent < words) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
			send_run(len, $urandom_range(3));
			sent += len;
		end
		drop_valid();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_single_word();
		test_spread();
		test_run_limit();

		send_idle_pct = 0;   stall_pct = 0;
		test_random_runs(125);
		send_idle_pct = 76;  stall_pct = 0;
		test_random_runs(125);
		send_idle_pct = 0;   stall_pct = 76;
		test_random_runs(125);
		send_idle_pct = 10;  stall_pct = 10;
		test_random_runs(125);

		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/sms_pkg.sv
rtl/sms_div.sv
rtl/sms_sqrt.sv
rtl/sms_dp.sv
rtl/sms_ctrl.sv
rtl/sample_mean_std_core.sv
tb/tb.sv
